// File: rtl/ndr_pkg.sv
// Shared types and constants for the nibble dequantize/requantize block.
// Used by the channel interfaces, the pipeline control, the lanes and the top level.
package ndr_pkg;

   // Field widths
   localparam int NIB_W      = 4;
   localparam int BYTE_W     = 8;
   localparam int SCALE_W    = 32;
   localparam int OFF_W      = 16;
   localparam int VAL_W      = 16;
   localparam int MAG_W      = 16;
   localparam int SAT_W      = 20;
   localparam int DEC_W      = 17;
   localparam int RES_W      = 22;

   // Exact product widths after each multiply
   localparam int P1_W       = MAG_W + SCALE_W;
   localparam int P2_W       = P1_W + SCALE_W;
   localparam int P3_W       = P2_W + SCALE_W;

   // Pipeline depth, not counting the output register
   localparam int NSTG       = 7;

   localparam int FRAC_BITS_DEF = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIGNED_MODE    = 3'd0,
      CSR_REQUANT_ENABLE = 3'd1,
      CSR_TABLE_SCALE    = 3'd2,
      CSR_TABLE_OFFSET   = 3'd3,
      CSR_GAIN_SCALE     = 3'd4,
      CSR_INV_OUT_SCALE  = 3'd5,
      CSR_OUT_BIAS       = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic                     signed_mode;
      logic                     requant_enable;
      logic [SCALE_W-1:0]       table_scale;
      logic signed [OFF_W-1:0]  table_offset;
      logic [SCALE_W-1:0]       gain_scale;
      logic [SCALE_W-1:0]       inv_out_scale;
      logic signed [OFF_W-1:0]  out_bias;
   } cfg_type;

   // load[k] moves stage k-1 into stage k; load[NSTG+1] fills the output register
   typedef struct packed {
      logic [NSTG+1:1] load;
   } pipe_ctl_type;

endpackage

// File: rtl/ndr_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on ndr_pkg for field widths.
interface ndr_req_if;
   import ndr_pkg::*;
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  packed_byte;
   logic [SCALE_W-1:0] row_scale;
   logic               last_in;

   modport source (output valid, packed_byte, row_scale, last_in, input ready);
   modport sink   (input valid, packed_byte, row_scale, last_in, output ready);
endinterface

interface ndr_rsp_if;
   import ndr_pkg::*;
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] low_value;
   logic [VAL_W-1:0] high_value;
   logic             last_out;

   modport source (output valid, low_value, high_value, last_out, input ready);
   modport sink   (input valid, low_value, high_value, last_out, output ready);
endinterface

// File: rtl/nibble_dequant_requant.sv
// Packed 4-bit embedding decoder, top level: registers, two decode lanes and
// the output register that merges them. Uses ndr_pkg, ndr_if, ndr_pipe_ctl, ndr_lane.
//
// Usage: each request transfer carries one packed byte (low nibble first),
// the row scale and a row-end flag. Each response transfer carries the two
// decoded 16-bit values and the row-end flag, one response per request.
// The two nibbles go through two identical lanes side by side.
// Each accepted request passes through seven lane stages, then the output
// register, before its response shows on rsp_ch.
// Throughput: one request per cycle while rsp_ch.ready is high, set by the fully
// pipelined lanes; every stage holds one item, so eight items may be in flight.
// Stall: when rsp_ch.ready is low the output register holds its result;
// upstream stages keep filling empty slots, and req_ch.ready drops only once
// every stage ahead of the input is occupied.
// Reset (synchronous, active high) empties the pipeline and restores the
// registers to unsigned mode, no requantization, unit scales, zero offsets.
// Registers are to be written through csr_we/csr_index/csr_wdata only while idle
// by the user; the block does not enforce it. An index beyond the list is ignored.
module nibble_dequant_requant #(
   parameter int FRAC_BITS = ndr_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   ndr_req_if.sink                          req_ch,
   ndr_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [ndr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ndr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ndr_pkg::*;

   localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(64'd1 << FRAC_BITS);

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   pipe_ctl_type     pipe;
   logic             stg_last;
   logic [VAL_W-1:0] low_lane;
   logic [VAL_W-1:0] high_lane;
   logic [VAL_W-1:0] low_ff;
   logic [VAL_W-1:0] high_ff;
   logic             last_ff;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_SIGNED_MODE:    cfg_in.signed_mode    = csr_wdata[0];
            CSR_REQUANT_ENABLE: cfg_in.requant_enable = csr_wdata[0];
            CSR_TABLE_SCALE:    cfg_in.table_scale    = csr_wdata[SCALE_W-1:0];
            CSR_TABLE_OFFSET:   cfg_in.table_offset   = signed'(csr_wdata[OFF_W-1:0]);
            CSR_GAIN_SCALE:     cfg_in.gain_scale     = csr_wdata[SCALE_W-1:0];
            CSR_INV_OUT_SCALE:  cfg_in.inv_out_scale  = csr_wdata[SCALE_W-1:0];
            CSR_OUT_BIAS:       cfg_in.out_bias       = signed'(csr_wdata[OFF_W-1:0]);
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.signed_mode    <= 1'b0;
         cfg_ff.requant_enable <= 1'b0;
         cfg_ff.table_scale    <= SCALE_ONE;
         cfg_ff.table_offset   <= '0;
         cfg_ff.gain_scale     <= SCALE_ONE;
         cfg_ff.inv_out_scale  <= SCALE_ONE;
         cfg_ff.out_bias       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ndr_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_last   (req_ch.last_in),
      .in_ready  (req_ch.ready),
      .out_ready (rsp_ch.ready),
      .out_valid (rsp_ch.valid),
      .stg_last  (stg_last),
      .pipe      (pipe)
   );

   ndr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_low (
      .clock     (clock),
      .cfg       (cfg_ff),
      .pipe      (pipe),
      .nib       (req_ch.packed_byte[NIB_W-1:0]),
      .row_scale (req_ch.row_scale),
      .value     (low_lane)
   );

   ndr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_high (
      .clock     (clock),
      .cfg       (cfg_ff),
      .pipe      (pipe),
      .nib       (req_ch.packed_byte[BYTE_W-1:NIB_W]),
      .row_scale (req_ch.row_scale),
      .value     (high_lane)
   );

   // Merge both lanes and the row-end flag into the output register
   always_ff @(posedge clock) begin
      if (pipe.load[NSTG+1]) begin
         low_ff  <= low_lane;
         high_ff <= high_lane;
         last_ff <= stg_last;
      end
   end

   assign rsp_ch.low_value  = low_ff;
   assign rsp_ch.high_value = high_ff;
   assign rsp_ch.last_out   = last_ff;

endmodule

// File: rtl/ndr_pipe_ctl.sv
// Valid tracking and stall control for the lane pipeline and output register.
// Carries the row-end flag alongside; depends on ndr_pkg.
module ndr_pipe_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  in_last,
   output logic                  in_ready,
   input  logic                  out_ready,
   output logic                  out_valid,
   output logic                  stg_last,
   output ndr_pkg::pipe_ctl_type pipe
);
   import ndr_pkg::*;

   logic [NSTG:1]   vld_ff;
   logic [NSTG:1]   vld_in;
   logic [NSTG:1]   last_ff;
   logic            out_vld_ff;
   logic            out_vld_in;
   logic [NSTG+1:1] free;

   // A stage may load when it is empty or its contents move on
   always_comb begin
      free[NSTG+1] = !out_vld_ff || out_ready;
      for (int k = NSTG; k >= 1; k--) begin
         free[k] = !vld_ff[k] || free[k+1];
      end
   end

   // Advance valid bits, hold where stalled
   always_comb begin
      vld_in[1] = free[1] ? in_valid : vld_ff[1];
      for (int k = 2; k <= NSTG; k++) begin
         vld_in[k] = free[k] ? vld_ff[k-1] : vld_ff[k];
      end
      out_vld_in = free[NSTG+1] ? vld_ff[NSTG] : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Row-end flag travels with the item
   always_ff @(posedge clock) begin
      if (free[1]) last_ff[1] <= in_last;
      for (int k = 2; k <= NSTG; k++) begin
         if (free[k]) last_ff[k] <= last_ff[k-1];
      end
   end

   assign pipe.load = free;
   assign in_ready  = free[1];
   assign out_valid = out_vld_ff;
   assign stg_last  = last_ff[NSTG];

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> vld_ff[1])
      else $error("accepted transfer did not enter the first stage");

   a_tail_reaches_out: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NSTG] && free[NSTG+1] |=> out_vld_ff)
      else $error("finished item did not reach the output register");

   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !out_ready && (&vld_ff) |-> !in_ready)
      else $error("input ready while every stage is full and stalled");

endmodule

// File: rtl/ndr_lane.sv
// One nibble decode lane: decode, three chained exact multiplies (the last two split
// into 32-bit partial products), truncate/clamp or round/offset/clamp. Uses ndr_pkg.
module ndr_lane #(
   parameter int FRAC_BITS = ndr_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  ndr_pkg::cfg_type              cfg,
   input  ndr_pkg::pipe_ctl_type         pipe,
   input  logic [ndr_pkg::NIB_W-1:0]     nib,
   input  logic [ndr_pkg::SCALE_W-1:0]   row_scale,
   output logic [ndr_pkg::VAL_W-1:0]     value
);
   import ndr_pkg::*;

   localparam int SH_PLAIN = 2 * FRAC_BITS;
   localparam int SH_REQ   = 3 * FRAC_BITS;
   localparam logic [P3_W:0] RND = (P3_W+1)'(1) << (SH_REQ - 1);
   localparam logic [VAL_W-1:0] VAL_MAX = '1;

   logic signed [DEC_W-1:0] dec;
   logic [DEC_W-1:0]        dec_abs;
   logic [SCALE_W-1:0]      sc_sel;

   logic [MAG_W-1:0]   mag1_ff;
   logic [SCALE_W-1:0] sc1_ff;
   logic [P1_W-1:0]    p1_ff;
   logic [63:0]        pl_ff;
   logic [P1_W-1:0]    ph_ff;
   logic [P2_W-1:0]    p2_ff;
   logic [63:0]        pa_ff;
   logic [63:0]        pb_ff;
   logic [P1_W-1:0]    pc_ff;
   logic [P1_W-1:0]    pc6_ff;
   logic [95:0]        pab_ff;
   logic [P3_W:0]      p3_ff;
   logic [NSTG:1]      neg_ff;
   logic [VAL_W-1:0]   plain_in;
   logic [VAL_W-1:0]   plain5_ff;
   logic [VAL_W-1:0]   plain6_ff;
   logic [VAL_W-1:0]   plain7_ff;

   logic [P2_W-1:0]         sh_plain;
   logic [P3_W:0]           sh_req;
   logic [SAT_W-1:0]        q_sat;
   logic signed [RES_W-1:0] q_signed;
   logic signed [RES_W-1:0] r_val;
   logic [VAL_W-1:0]        rq_val;

   // Decode the nibble into a signed value and pick the scale
   always_comb begin
      if (cfg.signed_mode) begin
         dec    = DEC_W'(signed'(nib));
         sc_sel = row_scale;
      end else begin
         dec    = signed'({{(DEC_W-NIB_W){1'b0}}, nib}) + DEC_W'(cfg.table_offset);
         sc_sel = cfg.table_scale;
      end
      dec_abs = dec[DEC_W-1] ? DEC_W'(-dec) : DEC_W'(dec);
   end

   // Stage 1: sign and magnitude
   always_ff @(posedge clock) begin
      if (pipe.load[1]) begin
         mag1_ff   <= dec_abs[MAG_W-1:0];
         sc1_ff    <= sc_sel;
         neg_ff[1] <= dec[DEC_W-1];
      end
   end

   // Stage 2: magnitude times scale
   always_ff @(posedge clock) begin
      if (pipe.load[2]) begin
         p1_ff     <= P1_W'(mag1_ff) * P1_W'(sc1_ff);
         neg_ff[2] <= neg_ff[1];
      end
   end

   // Stage 3: partial products with the gain scale
   always_ff @(posedge clock) begin
      if (pipe.load[3]) begin
         pl_ff     <= 64'(p1_ff[31:0]) * 64'(cfg.gain_scale);
         ph_ff     <= P1_W'(p1_ff[P1_W-1:32]) * P1_W'(cfg.gain_scale);
         neg_ff[3] <= neg_ff[2];
      end
   end

   // Stage 4: combine into the exact gain-scaled product
   always_ff @(posedge clock) begin
      if (pipe.load[4]) begin
         p2_ff     <= P2_W'(pl_ff) + {ph_ff, 32'b0};
         neg_ff[4] <= neg_ff[3];
      end
   end

   // Plain path: truncate the fraction, saturate, negative gives zero
   always_comb begin
      sh_plain = p2_ff >> SH_PLAIN;
      if (neg_ff[4]) plain_in = '0;
      else if (|sh_plain[P2_W-1:VAL_W]) plain_in = VAL_MAX;
      else plain_in = sh_plain[VAL_W-1:0];
   end

   // Stage 5: partial products with inv_out_scale
   always_ff @(posedge clock) begin
      if (pipe.load[5]) begin
         pa_ff     <= 64'(p2_ff[31:0]) * 64'(cfg.inv_out_scale);
         pb_ff     <= 64'(p2_ff[63:32]) * 64'(cfg.inv_out_scale);
         pc_ff     <= P1_W'(p2_ff[P2_W-1:64]) * P1_W'(cfg.inv_out_scale);
         plain5_ff <= plain_in;
         neg_ff[5] <= neg_ff[4];
      end
   end

   // Stage 6: sum the two low partial products
   always_ff @(posedge clock) begin
      if (pipe.load[6]) begin
         pab_ff    <= 96'(pa_ff) + {pb_ff, 32'b0};
         pc6_ff    <= pc_ff;
         plain6_ff <= plain5_ff;
         neg_ff[6] <= neg_ff[5];
      end
   end

   // Stage 7: full product plus the rounding half
   always_ff @(posedge clock) begin
      if (pipe.load[7]) begin
         p3_ff     <= (P3_W+1)'(pab_ff) + {1'b0, pc6_ff, 64'b0} + RND;
         plain7_ff <= plain6_ff;
         neg_ff[7] <= neg_ff[6];
      end
   end

   // Requantize: drop fraction, saturate, apply sign and offset, clamp
   always_comb begin
      sh_req   = p3_ff >> SH_REQ;
      q_sat    = (|sh_req[P3_W:SAT_W]) ? '1 : sh_req[SAT_W-1:0];
      q_signed = signed'(RES_W'(q_sat));
      if (neg_ff[7]) q_signed = -q_signed;
      r_val    = q_signed - RES_W'(cfg.out_bias);
      if (r_val[RES_W-1]) rq_val = '0;
      else if (|r_val[RES_W-2:VAL_W]) rq_val = VAL_MAX;
      else rq_val = r_val[VAL_W-1:0];
   end

   assign value = cfg.requant_enable ? rq_val : plain7_ff;

endmodule
